### hw/rtl/growable_bitset_store_macros.svh
// ----------------------------------------------------------------------------
// growable_bitset_store_macros.svh
// Assertion macros used by the bitset store RTL (gbs_ctrl). The module that uses them
// has clk and a synchronous active-high rst in scope.
// ----------------------------------------------------------------------------
`ifndef GROWABLE_BITSET_STORE_MACROS_SVH
`define GROWABLE_BITSET_STORE_MACROS_SVH

// same-cycle implication
`define GBS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gbs: same-cycle check failed");

// next-cycle implication
`define GBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gbs: next-cycle check failed");

`endif

### hw/rtl/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg
// Item types and command codes of the growable bitset store.
// ----------------------------------------------------------------------------
package gbs_pkg;

  localparam int CMD_W          = 3;
  localparam int INDEX_W        = 16;
  localparam int FIELD_W        = 13;
  localparam int DEFAULT_LENGTH = 64;

  localparam logic [CMD_W-1:0] CMD_GET       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TOGGLE    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SET_ALL   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR_ALL = 3'd5;
  localparam logic [CMD_W-1:0] CMD_INIT      = 3'd6;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [INDEX_W-1:0] bit_index;
  } in_item_t;

  typedef struct packed {
    logic               bit_value;
    logic [FIELD_W-1:0] ones_count;
    logic               is_empty;
    logic [FIELD_W-1:0] logical_length;
    logic               capacity_error;
  } out_item_t;

endpackage

### hw/rtl/gbs_word_ram.sv
// ----------------------------------------------------------------------------
// gbs_word_ram
// Word store of the bitset: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gbs_word_ram #(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/gbs_resp.sv
// ----------------------------------------------------------------------------
// gbs_resp
// Result register of the bitset store; frees the control side while a result
// waits on the output channel.
// ----------------------------------------------------------------------------
module gbs_resp (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  gbs_pkg::out_item_t  push_item,
  output logic                ready,
  output logic                out_valid,
  input  logic                out_stall,
  output gbs_pkg::out_item_t  out_item
);

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_item <= push_item;
    end
  end

endmodule

### hw/rtl/gbs_ctrl.sv
// ----------------------------------------------------------------------------
// gbs_ctrl
// Command sequencer: word read-modify-write for single-bit commands, one word
// per cycle sweeps for set_all, clear_all, init and the post-reset clear.
// ----------------------------------------------------------------------------
`include "growable_bitset_store_macros.svh"

module gbs_ctrl #(
  parameter int CAPACITY_BITS = 4096,
  parameter int WORD_BITS     = 64,
  localparam int NUM_WORDS    = CAPACITY_BITS / WORD_BITS,
  localparam int ADDR_W       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  gbs_pkg::in_item_t            in_item,
  input  logic                         cfg_we,
  input  logic [gbs_pkg::FIELD_W-1:0]  cfg_wdata,
  output logic                         ram_we,
  output logic [ADDR_W-1:0]            ram_waddr,
  output logic [WORD_BITS-1:0]         ram_wdata,
  output logic                         ram_re,
  output logic [ADDR_W-1:0]            ram_raddr,
  input  logic [WORD_BITS-1:0]         ram_rdata,
  input  logic                         resp_ready,
  output logic                         push,
  output gbs_pkg::out_item_t           push_item
);

  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int LEN_W  = $clog2(CAPACITY_BITS + 1);
  localparam int WIDE_W = gbs_pkg::INDEX_W + 1;
  localparam logic [WIDE_W-1:0] CAP_X = WIDE_W'(CAPACITY_BITS);

  typedef enum logic [1:0] {ST_IDLE, ST_MODIFY, ST_SWEEP} state_t;

  state_t                        state;
  logic [gbs_pkg::CMD_W-1:0]     cmd_r;
  logic [gbs_pkg::INDEX_W-1:0]   idx_r;
  logic [LEN_W-1:0]              length_reg;
  logic [LEN_W-1:0]              count_reg;
  logic [gbs_pkg::FIELD_W-1:0]   init_len;
  logic [ADDR_W-1:0]             sweep_addr;
  logic                          sweep_fill;
  logic                          sweep_reply;
  logic                          sweep_err;

  logic                          accept;
  logic [WIDE_W-1:0]             len_x;
  logic [WIDE_W-1:0]             idx_x;
  logic                          in_cap;
  logic                          beyond;
  logic [BIT_W-1:0]              bit_sel;
  logic [WORD_BITS-1:0]          mask;
  logic                          cur;
  logic                          m_we;
  logic [WORD_BITS-1:0]          m_wdata;
  logic [LEN_W-1:0]              m_len;
  logic [LEN_W-1:0]              m_cnt;
  logic                          m_bit;
  logic                          m_err;
  logic [WIDE_W-1:0]             base_x;
  logic [WIDE_W-1:0]             rem_x;
  logic [WORD_BITS-1:0]          fill;
  logic                          sweep_last;
  logic [gbs_pkg::FIELD_W-1:0]   ilen;
  logic                          init_over;

  assign accept    = in_valid && (state == ST_IDLE);
  assign in_stall  = (state != ST_IDLE);
  assign ram_re    = accept;
  assign ram_raddr = ADDR_W'(in_item.bit_index >> BIT_W);

  assign len_x   = WIDE_W'(length_reg);
  assign idx_x   = WIDE_W'(idx_r);
  assign in_cap  = idx_x < CAP_X;
  assign beyond  = idx_x >= len_x;
  assign bit_sel = idx_r[BIT_W-1:0];
  assign mask    = WORD_BITS'(1) << bit_sel;
  assign cur     = ram_rdata[bit_sel];

  always_comb begin
    m_we    = 1'b0;
    m_wdata = ram_rdata;
    m_len   = length_reg;
    m_cnt   = count_reg;
    m_bit   = 1'b0;
    m_err   = 1'b0;
    case (cmd_r)
      gbs_pkg::CMD_GET: begin
        m_bit = in_cap && !beyond && cur;
      end
      gbs_pkg::CMD_SET, gbs_pkg::CMD_TOGGLE: begin
        if (!in_cap) begin
          m_err = 1'b1;
        end else begin
          if (beyond) begin
            m_len = LEN_W'(idx_x + WIDE_W'(1));
          end
          if (!cur) begin
            m_we    = 1'b1;
            m_wdata = ram_rdata | mask;
            m_cnt   = count_reg + LEN_W'(1);
          end else if (cmd_r == gbs_pkg::CMD_TOGGLE) begin
            m_we    = 1'b1;
            m_wdata = ram_rdata & ~mask;
            m_cnt   = count_reg - LEN_W'(1);
          end
        end
      end
      gbs_pkg::CMD_CLEAR: begin
        if (in_cap && !beyond && cur) begin
          m_we    = 1'b1;
          m_wdata = ram_rdata & ~mask;
          m_cnt   = count_reg - LEN_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // fill word for set_all: full below the length, tail masked, zero past it
  assign base_x = WIDE_W'(sweep_addr) << BIT_W;
  assign rem_x  = len_x - base_x;

  always_comb begin
    if (len_x <= base_x) begin
      fill = '0;
    end else if (rem_x >= WIDE_W'(WORD_BITS)) begin
      fill = '1;
    end else begin
      fill = ~({WORD_BITS{1'b1}} << rem_x[BIT_W-1:0]);
    end
  end

  assign sweep_last = (sweep_addr == ADDR_W'(NUM_WORDS - 1));
  assign ilen       = (init_len == '0) ? gbs_pkg::FIELD_W'(gbs_pkg::DEFAULT_LENGTH) : init_len;
  assign init_over  = WIDE_W'(ilen) > CAP_X;

  always_comb begin
    if (state == ST_SWEEP) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_addr;
      ram_wdata = sweep_fill ? fill : '0;
      push      = sweep_last && sweep_reply && resp_ready;
      push_item.bit_value      = 1'b0;
      push_item.ones_count     = gbs_pkg::FIELD_W'(count_reg);
      push_item.is_empty       = (count_reg == '0);
      push_item.logical_length = gbs_pkg::FIELD_W'(length_reg);
      push_item.capacity_error = sweep_err;
    end else begin
      ram_we    = (state == ST_MODIFY) && resp_ready && m_we;
      ram_waddr = ADDR_W'(idx_r >> BIT_W);
      ram_wdata = m_wdata;
      push      = (state == ST_MODIFY) && resp_ready;
      push_item.bit_value      = m_bit;
      push_item.ones_count     = gbs_pkg::FIELD_W'(m_cnt);
      push_item.is_empty       = (m_cnt == '0);
      push_item.logical_length = gbs_pkg::FIELD_W'(m_len);
      push_item.capacity_error = m_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SWEEP;
      sweep_addr  <= '0;
      sweep_fill  <= 1'b0;
      sweep_reply <= 1'b0;
      sweep_err   <= 1'b0;
      length_reg  <= LEN_W'(gbs_pkg::DEFAULT_LENGTH);
      count_reg   <= '0;
      init_len    <= '0;
    end else begin
      if (cfg_we) begin
        init_len <= cfg_wdata;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_r       <= in_item.command;
            idx_r       <= in_item.bit_index;
            sweep_addr  <= '0;
            sweep_reply <= 1'b1;
            sweep_err   <= 1'b0;
            sweep_fill  <= 1'b0;
            case (in_item.command)
              gbs_pkg::CMD_SET_ALL: begin
                count_reg  <= length_reg;
                sweep_fill <= 1'b1;
                state      <= ST_SWEEP;
              end
              gbs_pkg::CMD_CLEAR_ALL: begin
                count_reg <= '0;
                state     <= ST_SWEEP;
              end
              gbs_pkg::CMD_INIT: begin
                count_reg  <= '0;
                length_reg <= init_over ? LEN_W'(CAPACITY_BITS) : LEN_W'(ilen);
                sweep_err  <= init_over;
                state      <= ST_SWEEP;
              end
              default: begin
                state <= ST_MODIFY;
              end
            endcase
          end
        end
        ST_MODIFY: begin
          if (resp_ready) begin
            length_reg <= m_len;
            count_reg  <= m_cnt;
            state      <= ST_IDLE;
          end
        end
        ST_SWEEP: begin
          if (!sweep_last) begin
            sweep_addr <= sweep_addr + ADDR_W'(1);
          end else if (!sweep_reply || resp_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `GBS_ASSERT_IMP(a_count_within_len, 1'b1, count_reg <= length_reg)
  `GBS_ASSERT_IMP(a_push_when_ready, push, resp_ready)
  `GBS_ASSERT_IMP(a_write_when_busy, ram_we, (state == ST_MODIFY) || (state == ST_SWEEP))
  `GBS_ASSERT_NEXT(a_bit_cmd_modifies, accept && (in_item.command != gbs_pkg::CMD_SET_ALL) && (in_item.command != gbs_pkg::CMD_CLEAR_ALL) && (in_item.command != gbs_pkg::CMD_INIT), state == ST_MODIFY)

endmodule

### hw/rtl/growable_bitset_store.sv
// ----------------------------------------------------------------------------
// growable_bitset_store
// Bit array in a word memory with a logical length and a running count of
// set bits; one result per command.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-------------------------
//   in       | in_valid / in_stall      | in_item  (in_item_t)
//   out      | out_valid / out_stall    | out_item (out_item_t)
//   config   | cfg_we                   | cfg_wdata (initial_length)
//
// get, set, clear, toggle: a word read then its write back, in_stall high until done.
// set_all, clear_all, init: a sweep over all CAPACITY_BITS / WORD_BITS words, one word
//   per cycle through the single write port.
// After reset a clearing pass over all CAPACITY_BITS / WORD_BITS words (64 at the
//   defaults) holds in_stall high.
// out_stall holds the result register; the next item is still taken, and its
//   write back waits until the register frees.
// ----------------------------------------------------------------------------
module growable_bitset_store #(
  parameter int CAPACITY_BITS = 4096,
  parameter int WORD_BITS     = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  gbs_pkg::in_item_t            in_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output gbs_pkg::out_item_t           out_item,
  input  logic                         cfg_we,
  input  logic [gbs_pkg::FIELD_W-1:0]  cfg_wdata
);

  localparam int NUM_WORDS = CAPACITY_BITS / WORD_BITS;
  localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [WORD_BITS-1:0]     ram_wdata;
  logic                     ram_re;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [WORD_BITS-1:0]     ram_rdata;
  logic                     resp_ready;
  logic                     push;
  gbs_pkg::out_item_t       push_item;

  gbs_ctrl #(
    .CAPACITY_BITS (CAPACITY_BITS),
    .WORD_BITS     (WORD_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .resp_ready (resp_ready),
    .push       (push),
    .push_item  (push_item)
  );

  gbs_word_ram #(
    .DEPTH  (NUM_WORDS),
    .DATA_W (WORD_BITS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gbs_resp u_resp (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .ready     (resp_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
